FILE: hw/rtl/integer_square_root_search_core_assert.svh
// assertion macros shared by the square root search core
`ifndef INTEGER_SQUARE_ROOT_SEARCH_CORE_ASSERT_SVH
`define INTEGER_SQUARE_ROOT_SEARCH_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ISRS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("isrs same-cycle check failed");
`define ISRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("isrs next-cycle check failed");
`else
`define ISRS_ASSERT_SAME(label, clk, rst, ante, cons)
`define ISRS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/isrs_pkg.sv
// shared widths and control/status types for the square root search core
package isrs_pkg;

  localparam int DATA_W      = 32;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int ROOT_W      = 17;
  localparam int OUT_TDATA_W = ((ROOT_W + 7) / 8) * 8;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [ROOT_W-1:0] root_t;

  typedef struct packed {
    logic load;
    logic square;
    logic decide;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic negative;
    logic eq;
    logic lt;
    logic cont_up;
    logic cont_dn;
    logic out_free;
  } status_t;

endpackage

FILE: hw/rtl/isrs_datapath.sv
// search datapath: bounds, midpoint squaring, compare and result register
`include "integer_square_root_search_core_assert.svh"
module isrs_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  isrs_pkg::cmd_t                         cmd,
  input  isrs_pkg::data_t                        value,
  output isrs_pkg::status_t                      status,
  input  logic                                   m_tready,
  output logic                                   m_tvalid,
  output logic [isrs_pkg::OUT_TDATA_W-1:0]       m_tdata
);
  import isrs_pkg::*;

  data_t               low;
  data_t               high;
  data_t               mid;
  data_t               best;
  data_t               target;
  data_t               mid_up;
  data_t               mid_dn;
  logic                cont_up;
  logic                cont_dn;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   target_ext;
  logic [DATA_W:0]     sum_up;
  logic [DATA_W:0]     sum_dn;
  logic                out_valid;
  root_t               out_root;

  assign target_ext = PROD_W'(target);
  // candidate sums for the next midpoint in either direction
  assign sum_up = {1'b0, mid} + {1'b0, high} + (DATA_W + 1)'(1);
  assign sum_dn = {1'b0, low} + {1'b0, mid} - (DATA_W + 1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
      low    <= '0;
      high   <= '0;
      best   <= '1;
    end else if (cmd.load) begin
      target <= value;
      low    <= '0;
      high   <= value;
      mid    <= value >> 1;
      best   <= '1;
    end else if (cmd.square) begin
      prod    <= PROD_W'(mid) * PROD_W'(mid);
      mid_up  <= sum_up[DATA_W:1];
      mid_dn  <= sum_dn[DATA_W:1];
      cont_up <= mid < high;
      cont_dn <= mid > low;
    end else if (cmd.decide) begin
      if (prod == target_ext) begin
        best <= mid;
      end else if (prod < target_ext) begin
        best <= mid;
        low  <= mid + DATA_W'(1);
        mid  <= mid_up;
      end else begin
        high <= mid - DATA_W'(1);
        mid  <= mid_dn;
      end
    end
  end

  // output register decouples the search from the downstream side
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_root <= best[ROOT_W-1:0];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_TDATA_W'(out_root);

  assign status.negative = value[DATA_W-1];
  assign status.eq       = prod == target_ext;
  assign status.lt       = prod < target_ext;
  assign status.cont_up  = cont_up;
  assign status.cont_dn  = cont_dn;
  assign status.out_free = !out_valid || m_tready;

  `ISRS_ASSERT_SAME(a_mid_in_range, clk, rst, cmd.square, (mid >= low) && (mid <= high))
  `ISRS_ASSERT_NEXT(a_neg_gives_ones, clk, rst, cmd.load && value[DATA_W-1], best == '1)
  `ISRS_ASSERT_SAME(a_finish_slot_free, clk, rst, cmd.finish, !out_valid || m_tready)

endmodule

FILE: hw/rtl/isrs_ctrl.sv
// search controller: sequences load, probe and result steps
`include "integer_square_root_search_core_assert.svh"
module isrs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  isrs_pkg::status_t  status,
  output isrs_pkg::cmd_t     cmd
);
  import isrs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SQUARE = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = status.negative ? ST_FINISH : ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        priority if (status.eq) begin
          state_next = ST_FINISH;
        end else if (status.lt) begin
          state_next = status.cont_up ? ST_SQUARE : ST_FINISH;
        end else begin
          state_next = status.cont_dn ? ST_SQUARE : ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign s_tready = state == ST_IDLE;

  `ISRS_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, s_tvalid && s_tready, state != ST_IDLE)
  `ISRS_ASSERT_NEXT(a_blocked_finish_holds, clk, rst, (state == ST_FINISH) && !status.out_free, state == ST_FINISH)
  `ISRS_ASSERT_SAME(a_square_then_decide, clk, rst, state == ST_DECIDE, $past(state) == ST_SQUARE)

endmodule

FILE: hw/rtl/integer_square_root_search_core.sv
// top level of the integer square root binary search core
// Returns the floor square root of a signed 32-bit request, or -1 for a negative request.
// One request is in flight at a time: a load step, then for each probe a square step (the
// midpoint is squared into a register) and a decide step (it is compared and the bounds
// updated), and a final step that moves the answer into the output register. A search
// over 0..value makes at most 31 probes; a negative request skips the probes and goes
// from the load straight to the final step. The move into the output register waits while an earlier result
// is still held there. The output register lets the next request load while a result waits.
module integer_square_root_search_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [isrs_pkg::DATA_W-1:0]          s_tdata,   // [31:0] value
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [isrs_pkg::OUT_TDATA_W-1:0]     m_tdata    // [16:0] root, rest zero
);
  import isrs_pkg::*;

  cmd_t    cmd;
  status_t status;

  isrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  isrs_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .value    (s_tdata),
    .status   (status),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

endmodule
